// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Offset and depth widths, token kinds, character codes and the record that
// carries the results of one text byte from the scanner to the output stage.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int DEPTH_BITS  = 16;
  localparam int OUT_W       = 32;

  // result slots of one byte: mode close, fresh unknown byte, end close, end
  localparam int SLOTS      = 4;
  localparam int SLOT_IW    = $clog2(SLOTS);
  localparam int SLOT_MODE  = 0;
  localparam int SLOT_FRESH = 1;
  localparam int SLOT_CLOSE = 2;
  localparam int SLOT_END   = 3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef logic [OFFSET_BITS-1:0] ofs_t;
  typedef logic [DEPTH_BITS-1:0]  depth_t;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_LINE    = 3'd2,
    KIND_BLOCK   = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_END     = 3'd5
  } kind_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] len;
  } slot_t;

  typedef struct packed {
    slot_t [SLOTS-1:0] slots;
  } rec_t;

  // queue handshake between scanner, queue and output stage
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_sts_t;

  // low bits of an offset, zero-extended when the offset is narrower
  function automatic logic [OUT_W-1:0] to_out(ofs_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_W-1:0];
  endfunction

endpackage

// ===== hdl/source_text_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_top: streaming source text tokenizer
// Scans text one byte a beat and reports identifiers, comments, strings,
// unknown bytes and the end of text with their start offset and length.
// ----------------------------------------------------------------------------
// The input side takes one byte every cycle while full is low; the scanner
// updates its state in the same cycle and writes the results that the byte
// closes, one to three of them, as one record into a four-entry queue; a byte
// that closes none writes nothing. The output side delivers one result per
// cycle while pop is high; full rises only when four records are waiting.
// run_last marks the last result caused by a byte. After the end token all
// further bytes are accepted and dropped until reset.
module source_text_tokenizer_top import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  token_kind,
  output logic [31:0] token_start,
  output logic [31:0] token_length,
  output logic        run_last
);

  q_ctl_t q_ctl;
  q_sts_t q_sts;
  rec_t   wr_data;
  rec_t   rd_data;
  logic   wr_en;
  logic   rd_en;

  assign q_ctl.wr_en = wr_en;
  assign q_ctl.rd_en = rd_en;
  assign full        = q_sts.full;

  stt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .q_full      (q_sts.full),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .wr_en       (wr_en),
    .wr_data     (wr_data)
  );

  stt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (q_ctl),
    .wr_data (wr_data),
    .sts     (q_sts),
    .rd_data (rd_data)
  );

  stt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_sts        (q_sts),
    .rd_data      (rd_data),
    .rd_en        (rd_en),
    .pop          (pop),
    .empty        (empty),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .run_last     (run_last)
  );

endmodule

// ===== hdl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front: byte scanner
// Takes one text byte a cycle while the queue is not full, tracks the open token
// and builds the record of results that the byte closes.
// ----------------------------------------------------------------------------
module stt_front import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       q_full,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       wr_en,
  output rec_t       wr_data
);

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_SLASH  = 6'b000010,
    MODE_IDENT  = 6'b000100,
    MODE_LINE   = 6'b001000,
    MODE_BLOCK  = 6'b010000,
    MODE_STRING = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_STAR  = 2'd1,
    CLS_SLASH = 2'd2
  } cls_t;

  localparam ofs_t   ONE       = ofs_t'(1);
  localparam depth_t DEPTH_MAX = '1;

  mode_t  mode, mode_next;
  ofs_t   offset, offset_next;
  ofs_t   open_start, open_start_next;
  depth_t depth, depth_next;
  cls_t   prev, prev_next;
  logic   esc, esc_next;
  logic   finished, finished_next;

  logic   accept;
  logic   fresh;
  ofs_t   offset_inc;
  depth_t depth_dec;
  rec_t   rec;
  logic [SLOTS-1:0] valid_vec;

  function automatic logic is_space(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C ||
           b == 8'h0D;
  endfunction

  function automatic logic is_ident_first(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
  endfunction

  function automatic logic is_ident_more(logic [7:0] b);
    return is_ident_first(b) || (b >= 8'h30 && b <= 8'h39);
  endfunction

  function automatic slot_t mk_slot(kind_t k, ofs_t s, ofs_t n);
    slot_t r;
    r.valid = 1'b1;
    r.kind  = k;
    r.start = to_out(s);
    r.len   = to_out(n);
    return r;
  endfunction

  // close whatever token is open when the text ends
  function automatic slot_t close_slot(mode_t m, ofs_t s, ofs_t e);
    slot_t r;
    r = '0;
    case (m)
      MODE_SLASH:  r = mk_slot(KIND_UNKNOWN, s, ONE);
      MODE_IDENT:  r = mk_slot(KIND_IDENT, s, ofs_t'(e - s));
      MODE_LINE:   r = mk_slot(KIND_LINE, s, ofs_t'(e - s));
      MODE_BLOCK:  r = mk_slot(KIND_BLOCK, s, ofs_t'(e - s));
      MODE_STRING: r = mk_slot(KIND_STRING, s, ofs_t'(e - s));
      default:     r = '0;
    endcase
    return r;
  endfunction

  assign accept     = push && !q_full;
  assign offset_inc = ofs_t'(offset + ONE);
  assign depth_dec  = (depth != '0) ? depth_t'(depth - depth_t'(1)) : depth;

  always_comb begin
    mode_next       = mode;
    offset_next     = offset;
    open_start_next = open_start;
    depth_next      = depth;
    prev_next       = prev;
    esc_next        = esc;
    finished_next   = finished;
    fresh           = 1'b0;
    rec             = '0;
    if (!finished) begin
      if (text_byte == CH_NUL) begin
        rec.slots[SLOT_CLOSE] = close_slot(mode, open_start, offset);
        rec.slots[SLOT_END]   = mk_slot(KIND_END, offset, '0);
        mode_next     = MODE_IDLE;
        finished_next = 1'b1;
      end else begin
        case (mode)
          MODE_SLASH: begin
            if (text_byte == CH_SLASH) begin
              mode_next = MODE_LINE;
            end else if (text_byte == CH_STAR) begin
              mode_next  = MODE_BLOCK;
              depth_next = depth_t'(1);
              prev_next  = CLS_NONE;
            end else begin
              rec.slots[SLOT_MODE] = mk_slot(KIND_UNKNOWN, open_start, ONE);
              mode_next = MODE_IDLE;
              fresh     = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (!is_ident_more(text_byte)) begin
              rec.slots[SLOT_MODE] = mk_slot(KIND_IDENT, open_start,
                                             ofs_t'(offset - open_start));
              mode_next = MODE_IDLE;
              fresh     = 1'b1;
            end
          end
          MODE_LINE: begin
            if (text_byte == CH_NL) begin
              rec.slots[SLOT_MODE] = mk_slot(KIND_LINE, open_start,
                                             ofs_t'(offset - open_start));
              mode_next = MODE_IDLE;
              fresh     = 1'b1;
            end
          end
          MODE_BLOCK: begin
            if (text_byte == CH_STAR && prev == CLS_SLASH) begin
              if (depth != DEPTH_MAX) depth_next = depth_t'(depth + depth_t'(1));
              prev_next = CLS_NONE;
            end else if (text_byte == CH_SLASH && prev == CLS_STAR) begin
              prev_next  = CLS_NONE;
              depth_next = depth_dec;
              if (depth_dec == '0) begin
                rec.slots[SLOT_MODE] = mk_slot(KIND_BLOCK, open_start,
                                               ofs_t'(offset_inc - open_start));
                mode_next = MODE_IDLE;
              end
            end else if (text_byte == CH_STAR) begin
              prev_next = CLS_STAR;
            end else if (text_byte == CH_SLASH) begin
              prev_next = CLS_SLASH;
            end else begin
              prev_next = CLS_NONE;
            end
          end
          MODE_STRING: begin
            if (text_byte == CH_NL) begin
              esc_next = 1'b0;
              rec.slots[SLOT_MODE] = mk_slot(KIND_STRING, open_start,
                                             ofs_t'(offset_inc - open_start));
              mode_next = MODE_IDLE;
            end else if (esc) begin
              esc_next = 1'b0;
            end else if (text_byte == CH_QUOTE) begin
              rec.slots[SLOT_MODE] = mk_slot(KIND_STRING, open_start,
                                             ofs_t'(offset_inc - open_start));
              mode_next = MODE_IDLE;
            end else if (text_byte == CH_BSLASH) begin
              esc_next = 1'b1;
            end
          end
          default: begin
            mode_next = MODE_IDLE;
            fresh     = 1'b1;
          end
        endcase

        // start a new token on this byte
        if (fresh) begin
          open_start_next = offset;
          if (is_space(text_byte)) begin
            mode_next = MODE_IDLE;
          end else if (text_byte == CH_SLASH) begin
            mode_next = MODE_SLASH;
          end else if (text_byte == CH_QUOTE) begin
            mode_next = MODE_STRING;
            esc_next  = 1'b0;
          end else if (is_ident_first(text_byte)) begin
            mode_next = MODE_IDENT;
          end else begin
            rec.slots[SLOT_FRESH] = mk_slot(KIND_UNKNOWN, offset, ONE);
          end
        end

        offset_next = offset_inc;
        if (end_of_text) begin
          rec.slots[SLOT_CLOSE] = close_slot(mode_next, open_start_next, offset_inc);
          rec.slots[SLOT_END]   = mk_slot(KIND_END, offset_inc, '0);
          mode_next     = MODE_IDLE;
          finished_next = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) valid_vec[i] = rec.slots[i].valid;
  end

  assign wr_en   = accept && (valid_vec != '0);
  assign wr_data = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      offset     <= '0;
      open_start <= '0;
      depth      <= '0;
      prev       <= CLS_NONE;
      esc        <= 1'b0;
      finished   <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      offset     <= offset_next;
      open_start <= open_start_next;
      depth      <= depth_next;
      prev       <= prev_next;
      esc        <= esc_next;
      finished   <= finished_next;
    end
  end

endmodule

// ===== hdl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// stt_queue: record queue
// Short FIFO of per-byte result records between the scanner and the output
// stage, so each side can stall on its own.
// ----------------------------------------------------------------------------
module stt_queue import stt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  q_ctl_t ctl,
  input  rec_t   wr_data,
  output q_sts_t sts,
  output rec_t   rd_data
);

  rec_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign sts.full      = (count == QCNT_W'(QDEPTH));
  assign sts.not_empty = (count != '0);
  assign rd_data       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.wr_en) wr_ptr <= QPTR_W'(wr_ptr + QPTR_W'(1));
      if (ctl.rd_en) rd_ptr <= QPTR_W'(rd_ptr + QPTR_W'(1));
      if (ctl.wr_en && !ctl.rd_en) begin
        count <= QCNT_W'(count + QCNT_W'(1));
      end else if (ctl.rd_en && !ctl.wr_en) begin
        count <= QCNT_W'(count - QCNT_W'(1));
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> !sts.full)
    else $error("record written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_en |-> sts.not_empty)
    else $error("record read from an empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (ctl.wr_en && !ctl.rd_en) |=> count == QCNT_W'($past(count) + QCNT_W'(1)))
    else $error("queue count lost a write");

endmodule

// ===== hdl/stt_back.sv =====
// ----------------------------------------------------------------------------
// stt_back: result output stage
// Holds one record and hands out its valid results one beat at a time,
// oldest slot first, marking the last result of the byte.
// ----------------------------------------------------------------------------
module stt_back import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  q_sts_t      q_sts,
  input  rec_t        rd_data,
  output logic        rd_en,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  token_kind,
  output logic [31:0] token_start,
  output logic [31:0] token_length,
  output logic        run_last
);

  rec_t               cur;
  logic [SLOTS-1:0]   remain;
  logic [SLOTS-1:0]   low_bit;
  logic [SLOTS-1:0]   remain_after;
  logic [SLOTS-1:0]   load_mask;
  logic [SLOT_IW-1:0] sel;
  logic               take;
  logic               load;

  assign low_bit      = remain & SLOTS'(~remain + SLOTS'(1));
  assign remain_after = remain & ~low_bit;
  assign empty        = (remain == '0);
  assign take         = pop && !empty;
  // refill when idle or when the last result of the held record leaves
  assign load         = empty || (take && remain_after == '0);
  assign rd_en        = load && q_sts.not_empty;

  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (remain[i]) sel = SLOT_IW'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) load_mask[i] = rd_data.slots[i].valid;
  end

  assign token_kind   = cur.slots[sel].kind;
  assign token_start  = cur.slots[sel].start;
  assign token_length = cur.slots[sel].len;
  assign run_last     = (remain_after == '0);

  always_ff @(posedge clk) begin
    if (rd_en) cur <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (rd_en) begin
      remain <= load_mask;
    end else if (take) begin
      remain <= remain_after;
    end
  end

endmodule

// ===== sim/source_text_tokenizer_top_tb.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_tb: self-checking bench of the source text tokenizer
// Streams one long text through the queue ports with random idle bursts on both
// sides and checks every reported token against a cycle-free scanner model.
// The text holds a short hand-written opening, a nested block comment,
// random well-formed tokens mixed with noise, an end of text and bytes after it.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top_tb;
  import stt_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int RANDOM_BYTES = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int CALM_TAIL    = 40;
  localparam int TAIL_CYCLES  = 20;

  localparam string IDENT_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_SLASH, SCAN_IDENT, SCAN_LINE, SCAN_BLOCK, SCAN_STRING
  } scan_t;

  typedef enum logic [1:0] {PREV_NONE, PREV_STAR, PREV_SLASH} prev_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       drain;
  } text_beat_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        full;
  logic        empty;
  logic [2:0]  token_kind;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic        run_last;

  source_text_tokenizer_top dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .empty(empty),
    .pop(pop),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .run_last(run_last)
  );

  // scanner model state
  scan_t  mode      = SCAN_IDLE;
  ofs_t   next_ofs  = '0;
  ofs_t   tok_ofs   = '0;
  depth_t depth     = '0;
  prev_t  prev      = PREV_NONE;
  logic   esc       = 1'b0;
  logic   text_done = 1'b0;

  token_t     step_toks[$];
  token_t     expected_tokens[$];
  text_beat_t pending_bytes[$];

  logic   drain_next = 1'b0;
  longint beat_cost = 144;
  longint cycle_limit = 20000;
  longint cycle_count = 0;
  int     fault_count = 0;
  logic   byte_taken = 1'b0;
  logic   send_lazy = 1'b1;
  logic   take_lazy = 1'b1;
  int     send_gap = 0;
  int     take_gap = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic ident_head(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function void note_token(kind_t k, ofs_t s, ofs_t n);
    token_t t;
    t.kind  = k;
    t.start = 32'(s);
    t.len   = 32'(n);
    t.last  = 1'b0;
    step_toks.push_back(t);
  endfunction

  function void close_open(kind_t k, ofs_t stop);
    note_token(k, tok_ofs, stop - tok_ofs);
    mode = SCAN_IDLE;
  endfunction

  function void close_text();
    case (mode)
      SCAN_SLASH:  note_token(KIND_UNKNOWN, tok_ofs, 1);
      SCAN_IDENT:  close_open(KIND_IDENT, next_ofs);
      SCAN_LINE:   close_open(KIND_LINE, next_ofs);
      SCAN_BLOCK:  close_open(KIND_BLOCK, next_ofs);
      SCAN_STRING: close_open(KIND_STRING, next_ofs);
      default: ;
    endcase
    mode = SCAN_IDLE;
    text_done = 1'b1;
    note_token(KIND_END, next_ofs, 0);
  endfunction

  // advance the scanner by one accepted byte and queue the tokens it closes
  function void scan_byte(logic [7:0] b, logic fin);
    logic fresh;
    fresh = 1'b0;
    step_toks.delete();
    if (!text_done) begin
      if (b == CH_NUL) begin
        close_text();
      end else begin
        case (mode)
          SCAN_SLASH: begin
            if (b == CH_SLASH) begin
              mode = SCAN_LINE;
            end else if (b == CH_STAR) begin
              mode = SCAN_BLOCK;
              depth = depth_t'(1);
              prev = PREV_NONE;
            end else begin
              note_token(KIND_UNKNOWN, tok_ofs, 1);
              mode = SCAN_IDLE;
              fresh = 1'b1;
            end
          end
          SCAN_IDENT: begin
            if (!(ident_head(b) || (b >= "0" && b <= "9"))) begin
              close_open(KIND_IDENT, next_ofs);
              fresh = 1'b1;
            end
          end
          SCAN_LINE: begin
            if (b == CH_NL) begin
              close_open(KIND_LINE, next_ofs);
              fresh = 1'b1;
            end
          end
          SCAN_BLOCK: begin
            // a pair is judged on the previous byte only and uses up both bytes
            if (b == CH_STAR && prev == PREV_SLASH) begin
              if (depth != '1) depth++;
              prev = PREV_NONE;
            end else if (b == CH_SLASH && prev == PREV_STAR) begin
              prev = PREV_NONE;
              if (depth != 0) depth--;
              if (depth == 0) close_open(KIND_BLOCK, next_ofs + 1);
            end else if (b == CH_STAR) begin
              prev = PREV_STAR;
            end else if (b == CH_SLASH) begin
              prev = PREV_SLASH;
            end else begin
              prev = PREV_NONE;
            end
          end
          SCAN_STRING: begin
            // a newline ends the string even right after a backslash
            if (b == CH_NL) begin
              esc = 1'b0;
              close_open(KIND_STRING, next_ofs + 1);
            end else if (esc) begin
              esc = 1'b0;
            end else if (b == CH_QUOTE) begin
              close_open(KIND_STRING, next_ofs + 1);
            end else if (b == CH_BSLASH) begin
              esc = 1'b1;
            end
          end
          default: fresh = 1'b1;
        endcase
        if (fresh) begin
          tok_ofs = next_ofs;
          if (b == CH_SLASH) begin
            mode = SCAN_SLASH;
          end else if (b == CH_QUOTE) begin
            mode = SCAN_STRING;
            esc = 1'b0;
          end else if (ident_head(b)) begin
            mode = SCAN_IDENT;
          end else if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
            note_token(KIND_UNKNOWN, next_ofs, 1);
          end
        end
        next_ofs = next_ofs + 1;
        if (fin) close_text();
      end
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endfunction

  function void add_byte(logic [7:0] b, logic fin = 1'b0);
    text_beat_t beat;
    beat.value = b;
    beat.last  = fin;
    beat.drain = drain_next;
    drain_next = 1'b0;
    pending_bytes.push_back(beat);
    cycle_limit += beat_cost;
  endfunction

  function void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // driver: one beat offered per cycle unless idling or waiting for a drain
  always @(negedge clk) begin
    logic push_n;
    push_n = 1'b0;
    if (!rst) begin
      if (byte_taken) pending_bytes.pop_front();
      if (cycle_count[5:0] == 0) send_lazy = $urandom_range(0, 2) != 0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (send_lazy && pending_bytes.size() > CALM_TAIL &&
                   $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 7);
      end else if (pending_bytes.size() > 0 &&
                   !(pending_bytes[0].drain && expected_tokens.size() > 0)) begin
        push_n = 1'b1;
        text_byte <= pending_bytes[0].value;
        end_of_text <= pending_bytes[0].last;
      end
    end
    push <= push_n;
  end

  // receiver: stall in bursts while the bulk of the text is streaming
  always @(negedge clk) begin
    logic pop_n;
    pop_n = 1'b0;
    if (!rst) begin
      if (cycle_count[5:0] == 0) take_lazy = $urandom_range(0, 2) != 0;
      if (take_gap > 0) begin
        take_gap--;
      end else if (take_lazy && pending_bytes.size() > CALM_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(0, 7);
      end else begin
        pop_n = 1'b1;
      end
    end
    pop <= pop_n;
  end

  // monitor: predict on every accepted byte, then check the popped token
  always @(posedge clk) begin
    token_t want;
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      byte_taken = !rst && push && !full;
      if (byte_taken) scan_byte(text_byte, end_of_text);
      if (!rst && pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("cycle %0d: unexpected token kind %0d start %0d length %0d last %0b",
                     cycle_count, token_kind, token_start, token_length, run_last);
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind !== want.kind || token_start !== want.start ||
              token_length !== want.len || run_last !== want.last) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display("cycle %0d: token mismatch, expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       cycle_count, want.kind, want.start, want.len, want.last,
                       token_kind, token_start, token_length, run_last);
          end
        end
      end
    end
  end

  initial begin
    int base;
    int n;
    int depth_left;
    int pick;
    logic drain_set;

    // opening: every token kind but the end, character class extremes and corner pairs
    add_text("_Az9");
    add_byte(CH_TAB);
    add_text("/*/**/*/");
    add_byte(CH_VT);
    add_text("\"\\\"\n");
    add_text("\"e\\\n");
    add_text("//");
    add_byte(CH_CR);
    add_byte(CH_NL);
    add_text("/ ");
    drain_next = 1'b1;
    add_byte(8'hFF);
    add_byte(8'h01);
    add_byte(CH_FF);

    // nested block comment; inner opens and closes pair up
    add_text("/*");
    repeat (3) add_text("/*");
    repeat (4) add_text("*/");

    base = pending_bytes.size();
    drain_set = 1'b0;
    while (pending_bytes.size() - base < RANDOM_BYTES) begin
      if (!drain_set && pending_bytes.size() - base > RANDOM_BYTES / 2) begin
        drain_next = 1'b1;
        drain_set = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          add_byte(IDENT_CHARS[$urandom_range(0, 52)]);
          n = $urandom_range(0, 6);
          repeat (n) add_byte(IDENT_CHARS[$urandom_range(0, 62)]);
        end
        2: begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            pick = $urandom_range(0, 5);
            add_byte(pick == 5 ? CH_SPACE : 8'(CH_TAB + pick));
          end
        end
        3: begin
          add_text("//");
          n = $urandom_range(0, 8);
          repeat (n) add_byte(any_byte());
          add_byte(CH_NL);
        end
        4, 5: begin
          add_text("/*");
          depth_left = 1;
          n = $urandom_range(0, 12);
          while (depth_left > 0) begin
            if (n > 0) begin
              pick = $urandom_range(0, 5);
              if (pick == 0) begin
                add_text("/*");
                depth_left++;
              end else if (pick == 1) begin
                add_text("*/");
                depth_left--;
              end else begin
                add_byte(any_byte());
              end
              n--;
            end else begin
              add_text("*/");
              depth_left--;
            end
          end
        end
        6: begin
          add_byte(CH_QUOTE);
          n = $urandom_range(0, 8);
          repeat (n) begin
            if ($urandom_range(0, 4) == 0) add_byte(CH_BSLASH);
            add_byte(any_byte());
          end
          add_byte($urandom_range(0, 3) == 0 ? CH_NL : CH_QUOTE);
        end
        7: begin
          add_byte(CH_SLASH);
          add_byte(any_byte());
        end
        8: add_byte(any_byte());
        default: begin
          n = $urandom_range(1, 4);
          repeat (n) add_byte(any_byte());
        end
      endcase
    end

    // leave a token open or none, then end the text
    drain_next = 1'b1;
    case ($urandom_range(0, 5))
      1: add_text("ab");
      2: add_text("//x");
      3: add_text("/*x");
      4: add_text("\"q");
      5: add_byte(CH_SLASH);
      default: ;
    endcase
    case ($urandom_range(0, 2))
      0: add_byte(CH_NUL);
      1: add_byte(any_byte(), 1'b1);
      default: add_byte(CH_NUL, 1'b1);
    endcase
    // bytes after the end are taken and dropped
    add_byte(8'($urandom), 1'b1);
    add_byte(8'($urandom), 1'b0);
    repeat (3) add_byte(8'($urandom), 1'($urandom_range(0, 1)));

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_bytes.size() != 0 || expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_back.sv
hdl/source_text_tokenizer_top.sv
sim/source_text_tokenizer_top_tb.sv
